>>> rtl/sstt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted sparse trit table package
// Shared codes, field widths, the controller state type and the command
// bundle that the controller sends to the datapath.
// ----------------------------------------------------------------------------
package sstt_pkg;

  // Request codes carried on the input tuser.
  localparam logic [1:0] REQ_READ   = 2'd0;
  localparam logic [1:0] REQ_WRITE  = 2'd1;
  localparam logic [1:0] REQ_DELETE = 2'd2;

  // Trit values returned by a read.
  localparam logic [1:0] TRIT_FALSE   = 2'd0;
  localparam logic [1:0] TRIT_YES     = 2'd1;
  localparam logic [1:0] TRIT_UNKNOWN = 2'd2;

  // Completion status codes.
  localparam logic [1:0] STAT_DONE     = 2'd0;
  localparam logic [1:0] STAT_FULL     = 2'd1;
  localparam logic [1:0] STAT_NO_MATCH = 2'd2;

  // Fixed result field widths.
  localparam int TRIT_W = 2;
  localparam int STAT_W = 2;
  localparam int HELD_W = 7;
  localparam int REQ_W  = 2;

  // Controller states.
  typedef enum logic [0:0] {
    ST_IDLE,
    ST_CMP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture the request and register the compare vectors
    logic apply;  // update the table and load the result register
  } cmd_t;

endpackage
`default_nettype wire

>>> rtl/sorted_sparse_trit_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted sparse trit table
// A sparse three-valued set held as a sorted chain of index/truth entries.
//
// Input stream: in_tuser carries the request kind (read, write, delete);
// in_tdata carries the index and the truth bit. Each request produces one
// result transaction on the output stream with the trit value, a status
// code and the number of entries held after the request.
// Each request runs in order: on acceptance the key is compared against every
// valid entry of the register chain and the compare vectors are registered;
// then the chain shifts and the result register loads, raising out_tvalid.
// A new request is accepted only once the last one has loaded its result.
// The next request is taken while a result waits; when the receiver stalls
// the block holds its compare state until the result register drains.
// Reset empties the table; entry contents are unspecified until written.
// A write of a new index into a full table is rejected with a full status.
// ----------------------------------------------------------------------------
module sorted_sparse_trit_table #(
  parameter int CAPACITY   = 64,
  parameter int INDEX_BITS = 15
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // Fields from bit 0: item_index, truth, zero fill.
  input  wire logic [((INDEX_BITS+8)/8)*8-1:0] in_tdata,
  // Fields from bit 0: req_type.
  input  wire logic [sstt_pkg::REQ_W-1:0]    in_tuser,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // Fields from bit 0: trit_value, status, entries_held, zero fill.
  output logic [15:0]                        out_tdata
);

  sstt_pkg::cmd_t              cmd;
  logic [sstt_pkg::TRIT_W-1:0] trit;
  logic [sstt_pkg::STAT_W-1:0] status;
  logic [sstt_pkg::HELD_W-1:0] held;

  sstt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  sstt_datapath #(
    .CAPACITY   (CAPACITY),
    .INDEX_BITS (INDEX_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_req     (in_tuser),
    .in_key     (in_tdata[INDEX_BITS-1:0]),
    .in_truth   (in_tdata[INDEX_BITS]),
    .out_trit   (trit),
    .out_status (status),
    .out_held   (held)
  );

  // Pack the result fields, lowest first.
  assign out_tdata = {5'd0, held, status, trit};

endmodule
`default_nettype wire

>>> rtl/sstt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted sparse trit table controller
// Two-state sequencer: accept a request, then apply it once the result
// register is free. Owns the output valid flag.
// ----------------------------------------------------------------------------
module sstt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output sstt_pkg::cmd_t     cmd
);

  sstt_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             can_apply;

  // The result register can take a new result when empty or being drained.
  assign can_apply = !out_valid_r || out_tready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sstt_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = sstt_pkg::ST_CMP;
      end
      sstt_pkg::ST_CMP: begin
        if (can_apply) state_nxt = sstt_pkg::ST_IDLE;
      end
      default: state_nxt = sstt_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_tready = 1'b0;
    cmd.load  = 1'b0;
    cmd.apply = 1'b0;
    case (state_r)
      sstt_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      sstt_pkg::ST_CMP: begin
        cmd.apply = can_apply;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // Output valid flag: set by a new result, cleared when the transaction ends.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.apply) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sstt_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/sstt_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted sparse trit table datapath
// A sorted register chain of entries. All valid entries are compared with the
// key as a request is accepted and the compare vectors are registered; then the
// chain shifts to insert or delete and the result register loads.
// ----------------------------------------------------------------------------
module sstt_datapath #(
  parameter int CAPACITY   = 64,
  parameter int INDEX_BITS = 15
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire sstt_pkg::cmd_t              cmd,
  input  wire logic [sstt_pkg::REQ_W-1:0]  in_req,
  input  wire logic [INDEX_BITS-1:0]       in_key,
  input  wire logic                        in_truth,
  output logic [sstt_pkg::TRIT_W-1:0]      out_trit,
  output logic [sstt_pkg::STAT_W-1:0]      out_status,
  output logic [sstt_pkg::HELD_W-1:0]      out_held
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Entry chain: index and a flag set when the truth is false.
  logic [INDEX_BITS-1:0] idx_r [CAPACITY];
  logic [INDEX_BITS-1:0] idx_nxt [CAPACITY];
  logic [CAPACITY-1:0]   neg_r, neg_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;

  // Captured request and registered compare vectors.
  logic [sstt_pkg::REQ_W-1:0] req_r;
  logic [INDEX_BITS-1:0]      key_r;
  logic                       truth_r;
  logic [CAPACITY-1:0]        lt_r, lt_nxt;
  logic [CAPACITY-1:0]        eq_r, eq_nxt;

  // Result register.
  logic [sstt_pkg::TRIT_W-1:0] trit_r, trit_nxt;
  logic [sstt_pkg::STAT_W-1:0] stat_r, stat_nxt;
  logic [31:0]                 held_ext;

  logic hit, hit_neg, full;

  // Compare every valid entry with the incoming key.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      lt_nxt[i] = (count_r > CNT_W'(i)) && (idx_r[i] < in_key);
      eq_nxt[i] = (count_r > CNT_W'(i)) && (idx_r[i] == in_key);
    end
  end

  // Hit detection and truth of the hit entry.
  always_comb begin
    hit     = 1'b0;
    hit_neg = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit     = hit | eq_r[i];
      hit_neg = hit_neg | (eq_r[i] & neg_r[i]);
    end
  end

  assign full = (count_r == CNT_W'(CAPACITY));

  // Table update and result for the captured request.
  always_comb begin
    logic prev_lt;
    idx_nxt   = idx_r;
    neg_nxt   = neg_r;
    count_nxt = count_r;
    trit_nxt  = sstt_pkg::TRIT_FALSE;
    stat_nxt  = sstt_pkg::STAT_DONE;
    prev_lt   = 1'b0;
    case (req_r)
      sstt_pkg::REQ_READ: begin
        if (hit) trit_nxt = hit_neg ? sstt_pkg::TRIT_FALSE : sstt_pkg::TRIT_YES;
        else     trit_nxt = sstt_pkg::TRIT_UNKNOWN;
      end
      sstt_pkg::REQ_WRITE: begin
        if (hit) begin
          // Replace the truth in place.
          for (int i = 0; i < CAPACITY; i++) begin
            if (eq_r[i]) neg_nxt[i] = !truth_r;
          end
        end else if (full) begin
          stat_nxt = sstt_pkg::STAT_FULL;
        end else begin
          // Shift entries at and above the insert point up by one.
          for (int i = 0; i < CAPACITY; i++) begin
            prev_lt = (i == 0) ? 1'b1 : lt_r[(i == 0) ? 0 : i - 1];
            if (!lt_r[i]) begin
              if (prev_lt) begin
                idx_nxt[i] = key_r;
                neg_nxt[i] = !truth_r;
              end else begin
                idx_nxt[i] = idx_r[(i == 0) ? 0 : i - 1];
                neg_nxt[i] = neg_r[(i == 0) ? 0 : i - 1];
              end
            end
          end
          count_nxt = count_r + CNT_W'(1);
        end
      end
      sstt_pkg::REQ_DELETE: begin
        if (hit && (hit_neg == !truth_r)) begin
          // Shift entries above the match down by one.
          for (int i = 0; i < CAPACITY; i++) begin
            if (!lt_r[i]) begin
              idx_nxt[i] = idx_r[(i == CAPACITY - 1) ? i : i + 1];
              neg_nxt[i] = neg_r[(i == CAPACITY - 1) ? i : i + 1];
            end
          end
          count_nxt = count_r - CNT_W'(1);
        end else begin
          stat_nxt = sstt_pkg::STAT_NO_MATCH;
        end
      end
      default: begin
        trit_nxt = sstt_pkg::TRIT_UNKNOWN;
      end
    endcase
  end

  // Entry count register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.apply) begin
      count_r <= count_nxt;
    end
  end

  // Entry chain, request capture and result registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r   <= in_req;
      key_r   <= in_key;
      truth_r <= in_truth;
      lt_r    <= lt_nxt;
      eq_r    <= eq_nxt;
    end
    if (cmd.apply) begin
      idx_r  <= idx_nxt;
      neg_r  <= neg_nxt;
      trit_r <= trit_nxt;
      stat_r <= stat_nxt;
    end
  end

  // The count register already holds the post-update value with the result.
  assign held_ext   = 32'(count_r);
  assign out_held   = held_ext[sstt_pkg::HELD_W-1:0];
  assign out_trit   = trit_r;
  assign out_status = stat_r;

endmodule
`default_nettype wire

>>> test/tb_sorted_sparse_trit_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the sorted sparse trit table
// Drives read, write and delete requests on the input stream and checks each
// result transaction against a behavioral model of the sorted table. The run
// covers directed corner cases, a fill past capacity, a long receiver stall
// and random traffic over a small key pool, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_sorted_sparse_trit_table;

  localparam int CAPACITY    = 64;
  localparam int INDEX_BITS  = 15;
  localparam int DATA_W      = ((INDEX_BITS + 8) / 8) * 8;
  localparam int POOL_SIZE   = 80;
  localparam int HOLD_CYCLES = 150;
  localparam logic [1:0] REQ_NOP = 2'd3;
  localparam logic [INDEX_BITS-1:0] KEY_MAX = {INDEX_BITS{1'b1}};

  typedef struct packed {
    logic [sstt_pkg::TRIT_W-1:0] trit;
    logic [sstt_pkg::STAT_W-1:0] status;
    logic [sstt_pkg::HELD_W-1:0] held;
  } trit_result_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  // Fields from bit 0: item_index, truth.
  logic [DATA_W-1:0] in_tdata;
  // Fields from bit 0: req_type.
  logic [sstt_pkg::REQ_W-1:0] in_tuser;
  logic              out_tvalid;
  logic              out_tready;
  // Fields from bit 0: trit_value, status, entries_held, zero fill.
  logic [15:0]       out_tdata;

  // Model of the table: sorted indexes with their truth bits.
  logic [INDEX_BITS-1:0] model_index [CAPACITY];
  logic                  model_truth [CAPACITY];
  int                    model_count;

  trit_result_t          pending_results [$];
  logic [INDEX_BITS-1:0] key_pool [POOL_SIZE];
  int                    mismatch_count;
  logic                  idle_on;
  logic                  hold_request;

  sorted_sparse_trit_table #(
    .CAPACITY  (CAPACITY),
    .INDEX_BITS(INDEX_BITS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #2 clk = ~clk;

  // Apply one request to the model table and return the result it causes.
  function automatic trit_result_t predict_trit_request(logic [1:0] req,
                                                        logic [INDEX_BITS-1:0] key,
                                                        logic tr);
    trit_result_t r;
    int pos;
    int i;
    bit hit;
    r.trit   = sstt_pkg::TRIT_FALSE;
    r.status = sstt_pkg::STAT_DONE;
    pos = 0;
    for (i = 0; i < model_count; i++) begin
      if (model_index[i] < key) pos++;
    end
    hit = (pos < model_count) && (model_index[pos] == key);
    case (req)
      sstt_pkg::REQ_READ: begin
        if (hit) r.trit = model_truth[pos] ? sstt_pkg::TRIT_YES : sstt_pkg::TRIT_FALSE;
        else r.trit = sstt_pkg::TRIT_UNKNOWN;
      end
      sstt_pkg::REQ_WRITE: begin
        if (hit) begin
          model_truth[pos] = tr;
        end else if (model_count >= CAPACITY) begin
          r.status = sstt_pkg::STAT_FULL;
        end else begin
          for (i = model_count; i > pos; i--) begin
            model_index[i] = model_index[i-1];
            model_truth[i] = model_truth[i-1];
          end
          model_index[pos] = key;
          model_truth[pos] = tr;
          model_count++;
        end
      end
      sstt_pkg::REQ_DELETE: begin
        if (hit && model_truth[pos] == tr) begin
          for (i = pos; i + 1 < model_count; i++) begin
            model_index[i] = model_index[i+1];
            model_truth[i] = model_truth[i+1];
          end
          model_count--;
        end else begin
          r.status = sstt_pkg::STAT_NO_MATCH;
        end
      end
      default: r.trit = sstt_pkg::TRIT_UNKNOWN;
    endcase
    r.held = model_count[sstt_pkg::HELD_W-1:0];
    return r;
  endfunction

  // Offer one request, optionally after an idle burst, and record its result
  // once the transaction is accepted.
  task automatic send_request(input logic [1:0] req, input logic [INDEX_BITS-1:0] key,
                              input logic tr);
    int gap;
    if (idle_on && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 7);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= DATA_W'({tr, key});
    in_tuser  <= req;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(predict_trit_request(req, key, tr));
  endtask

  // Random request, mostly on pooled keys so that hits and a full table occur.
  task automatic send_random_request();
    logic [1:0] req;
    logic [INDEX_BITS-1:0] key;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) req = sstt_pkg::REQ_READ;
    else if (pick < 62) req = sstt_pkg::REQ_WRITE;
    else if (pick < 95) req = sstt_pkg::REQ_DELETE;
    else req = REQ_NOP;
    if ($urandom_range(0, 9) < 8) key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    else key = INDEX_BITS'($urandom_range(0, KEY_MAX));
    send_request(req, key, 1'($urandom_range(0, 1)));
  endtask

  // Corner cases on a small table: empty reads and deletes, extreme indexes,
  // replacement, mismatched truth, a delete past the last entry, code three.
  task automatic test_directed();
    send_request(sstt_pkg::REQ_READ,   '0,      1'b1);
    send_request(sstt_pkg::REQ_DELETE, 15'd5,   1'b1);
    send_request(REQ_NOP,              '0,      1'b0);
    send_request(sstt_pkg::REQ_WRITE,  '0,      1'b1);
    send_request(sstt_pkg::REQ_WRITE,  15'd100, 1'b1);
    send_request(sstt_pkg::REQ_DELETE, 15'd30000, 1'b1);
    send_request(sstt_pkg::REQ_WRITE,  KEY_MAX, 1'b0);
    send_request(sstt_pkg::REQ_READ,   '0,      1'b0);
    send_request(sstt_pkg::REQ_READ,   KEY_MAX, 1'b1);
    send_request(sstt_pkg::REQ_READ,   15'd50,  1'b0);
    send_request(sstt_pkg::REQ_READ,   KEY_MAX - 15'd1, 1'b0);
    send_request(sstt_pkg::REQ_WRITE,  15'd100, 1'b0);
    send_request(sstt_pkg::REQ_READ,   15'd100, 1'b1);
    send_request(sstt_pkg::REQ_DELETE, 15'd100, 1'b1);
    send_request(sstt_pkg::REQ_DELETE, 15'd100, 1'b0);
    send_request(sstt_pkg::REQ_READ,   15'd100, 1'b0);
    send_request(REQ_NOP,              KEY_MAX, 1'b1);
    send_request(sstt_pkg::REQ_DELETE, '0,      1'b1);
    send_request(sstt_pkg::REQ_DELETE, KEY_MAX, 1'b0);
    send_request(sstt_pkg::REQ_READ,   KEY_MAX, 1'b0);
  endtask

  // Build a pool of distinct keys and write all of them, so the table fills
  // and the later new keys are rejected; then rewrite a held key while full.
  task automatic test_fill_to_capacity();
    int i;
    int j;
    bit dup;
    key_pool[0] = '0;
    key_pool[1] = KEY_MAX;
    for (i = 2; i < POOL_SIZE; i++) begin
      do begin
        key_pool[i] = INDEX_BITS'($urandom_range(0, KEY_MAX));
        dup = 1'b0;
        for (j = 0; j < i; j++) begin
          if (key_pool[j] == key_pool[i]) dup = 1'b1;
        end
      end while (dup);
    end
    for (i = 0; i < POOL_SIZE; i++) begin
      send_request(sstt_pkg::REQ_WRITE, key_pool[i], 1'($urandom_range(0, 1)));
    end
    send_request(sstt_pkg::REQ_WRITE, key_pool[3], 1'b1);
    send_request(sstt_pkg::REQ_READ,  key_pool[3], 1'b0);
    send_request(sstt_pkg::REQ_WRITE, key_pool[3], 1'b0);
    send_request(sstt_pkg::REQ_READ,  key_pool[3], 1'b1);
  endtask

  // The receiver stops for a long stretch while requests keep coming.
  task automatic test_output_stall();
    int i;
    hold_request <= 1'b1;
    for (i = 0; i < 30; i++) send_random_request();
  endtask

  task automatic test_random_traffic();
    int i;
    for (i = 0; i < 300; i++) send_random_request();
  endtask

  // Back-to-back traffic with no idling on either side.
  task automatic test_full_rate();
    int i;
    idle_on <= 1'b0;
    for (i = 0; i < 60; i++) send_random_request();
  endtask

  // Main sequence.
  initial begin
    rst_n          <= 1'b0;
    in_tvalid      <= 1'b0;
    in_tdata       <= '0;
    in_tuser       <= sstt_pkg::REQ_READ;
    idle_on        <= 1'b1;
    hold_request   <= 1'b0;
    mismatch_count = 0;
    model_count    = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_fill_to_capacity();
    test_output_stall();
    test_random_traffic();
    test_full_rate();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_sorted_sparse_trit_table: clean");
    end else begin
      $display("tb_sorted_sparse_trit_table: errors");
    end
    $finish;
  end

  // Receiver: random stall bursts, plus one long hold on request.
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request <= 1'b0;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(0, 6);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Compare each accepted result transaction with the oldest expectation.
  always @(posedge clk) begin
    trit_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction: tdata %h", out_tdata);
        mismatch_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_tdata[1:0] !== exp_r.trit) begin
          $error("trit_value: expected %0d, actual %0d", exp_r.trit, out_tdata[1:0]);
          mismatch_count++;
        end
        if (out_tdata[3:2] !== exp_r.status) begin
          $error("status: expected %0d, actual %0d", exp_r.status, out_tdata[3:2]);
          mismatch_count++;
        end
        if (out_tdata[10:4] !== exp_r.held) begin
          $error("entries_held: expected %0d, actual %0d", exp_r.held, out_tdata[10:4]);
          mismatch_count++;
        end
        if (out_tdata[15:11] !== 5'd0) begin
          $error("zero fill: expected 0, actual %0h", out_tdata[15:11]);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog for a hung handshake or a missing result.
  initial begin
    #400000;
    $display("tb_sorted_sparse_trit_table: errors");
    $finish;
  end

endmodule
